### design/shthc_pkg.sv
// ----------------------------------------------------------------------------
// shthc_pkg
// Types, constants and tables shared by the self-heating temperature and
// humidity compensation block.
// ----------------------------------------------------------------------------
package shthc_pkg;

    // Fixed-point format and sensor constants.
    localparam int FRAC_BITS          = 8;
    localparam int CHIP_TEMP_FALLBACK = 12800;
    localparam int HUMID_LOW          = 0;
    localparam int HUMID_HIGH         = 25600;
    localparam int MAGNUS_A_Q         = 4511;
    localparam int MAGNUS_B_Q         = 62239;
    localparam int LOG2E_Q16          = 94548;
    localparam int LN2_Q16            = 45426;
    localparam int WEIGHT_MAX         = 65536;

    // Gamma division sizes: dividend A*|t|*2^(16-F), divisor B+t (> 2^F).
    localparam int A_W   = $clog2(MAGNUS_A_Q + 1);
    localparam int MAG_W = A_W + 15;
    localparam int NUM_W = MAG_W + 16 - FRAC_BITS;
    localparam int QW    = NUM_W - FRAC_BITS;
    localparam int DW    = $clog2(MAGNUS_B_Q + 32768 + 1);
    localparam int CW    = $clog2(QW + 1);

    // Result path codes.
    localparam logic [1:0] PATH_OFF    = 2'd0;
    localparam logic [1:0] PATH_FAST   = 2'd1;
    localparam logic [1:0] PATH_MAGNUS = 2'd2;
    localparam logic [1:0] PATH_GUARD  = 2'd3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ENABLE    = 3'd0,
        CFG_BASE      = 3'd1,
        CFG_REF       = 3'd2,
        CFG_SLOPE     = 3'd3,
        CFG_FLOOR     = 3'd4,
        CFG_CEILING   = 3'd5,
        CFG_WEIGHT    = 3'd6,
        CFG_FAST_LIM  = 3'd7
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FLT_MUL,
        ST_FLT_ADD,
        ST_OFS_MUL,
        ST_OFS_ADD,
        ST_TEMP,
        ST_GAM_MUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_END,
        ST_D_CLAMP,
        ST_Y_MUL,
        ST_Y,
        ST_T_MUL,
        ST_T,
        ST_TT_MUL,
        ST_P,
        ST_M_MUL,
        ST_M,
        ST_H_MUL,
        ST_H,
        ST_OUT
    } t_state;

    // 2^(i/16) in Q16.
    function automatic logic [16:0] pow2_frac(input logic [3:0] idx);
        logic [16:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd68438;
            4'd2:    v = 17'd71468;
            4'd3:    v = 17'd74632;
            4'd4:    v = 17'd77936;
            4'd5:    v = 17'd81386;
            4'd6:    v = 17'd84990;
            4'd7:    v = 17'd88752;
            4'd8:    v = 17'd92682;
            4'd9:    v = 17'd96785;
            4'd10:   v = 17'd101070;
            4'd11:   v = 17'd105545;
            4'd12:   v = 17'd110218;
            4'd13:   v = 17'd115097;
            4'd14:   v = 17'd120193;
            default: v = 17'd125515;
        endcase
        return v;
    endfunction

endpackage

### design/self_heating_temp_humidity_comp.sv
// ----------------------------------------------------------------------------
// self_heating_temp_humidity_comp
// Self-heating temperature offset and Magnus humidity correction.
// ----------------------------------------------------------------------------
// A beat carries raw temperature, raw humidity and a chip temperature sample
// in Q8.8. The block takes one beat at a time and returns one result beat.
// A disabled beat goes straight to the output register, a fast-path or guard
// beat passes the filter, offset and temperature steps, and a full Magnus
// beat adds the gamma divisions and the exponent steps; the beat that seeds
// the filter skips the filter multiply and add. The Magnus path is dominated
// by two gamma divisions on one restoring divider at one quotient bit per
// cycle (28 steps plus a load and an unload step), and all multiplies go
// through one shared 33x33 multiplier under a small sequencer. A new input
// beat is taken as soon as the sequencer is idle, even while the previous
// result still waits in the output register.
module self_heating_temp_humidity_comp
    import shthc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data,
    // Input channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_raw_temp,
    input  logic [14:0]        i_raw_humid,
    input  logic signed [15:0] i_chip_temp_sample,
    input  logic               i_chip_sample_valid,
    // Output channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_temp_out,
    output logic [14:0]        o_humid_out,
    output logic signed [15:0] o_temp_offset,
    output logic signed [15:0] o_humid_offset,
    output logic signed [15:0] o_chip_temp_smoothed,
    output logic [1:0]         o_path
);

    localparam logic signed [QW+1:0] D_LO = (QW+2)'(-12 * 65536);
    localparam logic signed [QW+1:0] D_HI = (QW+2)'(11 * 65536);
    localparam logic signed [19:0]   B_S  = 20'(MAGNUS_B_Q);
    localparam logic signed [19:0]   G_LIM = 20'(1 << FRAC_BITS);

    // Configuration registers.
    logic               r_en;
    logic signed [15:0] r_base, r_ref, r_slope, r_lo, r_hi;
    logic [16:0]        r_w;
    logic [14:0]        r_lim;

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    logic signed [15:0] r_raw_t, r_x, r_s, r_off, r_tc;
    logic [14:0]        r_raw_h, r_hum;
    logic [1:0]         r_path;
    logic               r_started;
    logic signed [48:0] r_prod;
    logic               r_gsel, r_neg;
    logic [DW-1:0]      r_div;
    logic [DW-1:0]      r_rem;
    logic [QW-1:0]      r_quo;
    logic [CW-1:0]      r_cnt;
    logic signed [QW:0] r_g_raw, r_g_cmp;
    logic signed [20:0] r_d;
    logic signed [5:0]  r_n;
    logic [15:0]        r_u;
    logic [11:0]        r_t;
    logic [30:0]        r_p;
    logic [31:0]        r_m;

    // Output register.
    logic               r_ov;
    logic signed [15:0] r_o_temp, r_o_toff, r_o_hoff, r_o_smooth;
    logic [14:0]        r_o_hum;
    logic [1:0]         r_o_path;

    // Shared multiplier.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Combinational helpers.
    logic [16:0]        w_sat;
    logic signed [16:0] xs_diff, sr_diff;
    logic signed [15:0] g_t;
    logic [16:0]        g_tabs;
    logic signed [48:0] flt_sum, ofs_sum;
    logic signed [35:0] ofs_raw;
    logic signed [15:0] lo_eff;
    logic signed [16:0] tc_wide, td_diff;
    logic signed [15:0] tc_sat;
    logic [16:0]        td_abs;
    logic               is_fast, is_guard;
    logic [14:0]        raw_h_clamp;
    logic [NUM_W-1:0]   dividend;
    logic [DW:0]        rem2;
    logic               q_bit;
    logic signed [QW:0] g_val;
    logic signed [QW+1:0] d_full;
    logic [6:0]         h_sh;
    logic [49:0]        h_sum, h_res;
    logic [14:0]        h_clamp;
    logic               out_load;

    assign w_sat   = (r_w > 17'(WEIGHT_MAX)) ? 17'(WEIGHT_MAX) : r_w;
    assign xs_diff = 17'(r_x) - 17'(r_s);
    assign sr_diff = 17'(r_s) - 17'(r_ref);
    assign g_t     = r_gsel ? r_tc : r_raw_t;
    assign g_tabs  = g_t[15] ? (17'd0 - 17'(g_t)) : 17'(g_t);

    // Filter and offset arithmetic.
    assign flt_sum = r_prod + 49'sd32768;
    assign ofs_sum = r_prod + 49'sd8192;
    assign ofs_raw = 36'(ofs_sum >>> 14) + 36'(r_base);
    assign lo_eff  = (r_lo > r_hi) ? r_hi : r_lo;

    // Compensated temperature and path decision.
    assign tc_wide = 17'(r_raw_t) - 17'(r_off);
    assign tc_sat  = (tc_wide > 17'sd32767)  ? 16'sh7fff :
                     (tc_wide < -17'sd32768) ? 16'sh8000 : 16'(tc_wide);
    assign td_diff = 17'(r_raw_t) - 17'(tc_sat);
    assign td_abs  = td_diff[16] ? (17'd0 - 17'(td_diff)) : 17'(td_diff);
    assign is_fast = td_abs < 17'(r_lim);
    assign is_guard = ((B_S + 20'(r_raw_t)) <= G_LIM) || ((B_S + 20'(tc_sat)) <= G_LIM);
    assign raw_h_clamp = (r_raw_h < 15'(HUMID_LOW))  ? 15'(HUMID_LOW) :
                         (r_raw_h > 15'(HUMID_HIGH)) ? 15'(HUMID_HIGH) : r_raw_h;

    // Restoring divider step.
    assign dividend = {r_prod[MAG_W-1:0], (16 - FRAC_BITS)'(0)};
    assign rem2     = {r_rem, r_quo[QW-1]};
    assign q_bit    = rem2 >= {1'b0, r_div};
    assign g_val    = r_neg ? ((QW+1)'(0) - (QW+1)'(r_quo)) : (QW+1)'(r_quo);
    assign d_full   = (QW+2)'(r_g_raw) - (QW+2)'(r_g_cmp);

    // Final scale by 2^n with rounding.
    assign h_sh    = 7'(7'sd30 - 7'(r_n));
    assign h_sum   = {1'b0, r_prod} + (50'd1 << (h_sh - 7'd1));
    assign h_res   = h_sum >> h_sh;
    assign h_clamp = (h_res < 50'(HUMID_LOW))  ? 15'(HUMID_LOW) :
                     (h_res > 50'(HUMID_HIGH)) ? 15'(HUMID_HIGH) : h_res[14:0];

    assign out_load = (r_state == ST_OUT) && (!r_ov || i_ready);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!r_en) begin
                        n_state = ST_OUT;
                    end else if (!r_started) begin
                        n_state = ST_OFS_MUL;
                    end else begin
                        n_state = ST_FLT_MUL;
                    end
                end
            end
            ST_FLT_MUL:  n_state = ST_FLT_ADD;
            ST_FLT_ADD:  n_state = ST_OFS_MUL;
            ST_OFS_MUL:  n_state = ST_OFS_ADD;
            ST_OFS_ADD:  n_state = ST_TEMP;
            ST_TEMP:     n_state = (is_fast || is_guard) ? ST_OUT : ST_GAM_MUL;
            ST_GAM_MUL:  n_state = ST_DIV_LOAD;
            ST_DIV_LOAD: n_state = ST_DIV;
            ST_DIV:      n_state = (r_cnt == CW'(1)) ? ST_DIV_END : ST_DIV;
            ST_DIV_END:  n_state = r_gsel ? ST_D_CLAMP : ST_GAM_MUL;
            ST_D_CLAMP:  n_state = ST_Y_MUL;
            ST_Y_MUL:    n_state = ST_Y;
            ST_Y:        n_state = ST_T_MUL;
            ST_T_MUL:    n_state = ST_T;
            ST_T:        n_state = ST_TT_MUL;
            ST_TT_MUL:   n_state = ST_P;
            ST_P:        n_state = ST_M_MUL;
            ST_M_MUL:    n_state = ST_M;
            ST_M:        n_state = ST_H_MUL;
            ST_H_MUL:    n_state = ST_H;
            ST_H:        n_state = ST_OUT;
            ST_OUT:      n_state = out_load ? ST_IDLE : ST_OUT;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Output logic: handshake and multiplier operand selection.
    always_comb begin
        o_ready = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            ST_IDLE:    o_ready = 1'b1;
            ST_FLT_MUL: begin
                mul_a = $signed({16'd0, w_sat});
                mul_b = 33'(xs_diff);
            end
            ST_OFS_MUL: begin
                mul_a = 33'(sr_diff);
                mul_b = 33'(r_slope);
            end
            ST_GAM_MUL: begin
                mul_a = 33'sd0 + 33'(MAGNUS_A_Q);
                mul_b = $signed({16'd0, g_tabs});
            end
            ST_Y_MUL: begin
                mul_a = 33'(r_d);
                mul_b = 33'(LOG2E_Q16);
            end
            ST_T_MUL: begin
                mul_a = $signed({21'd0, r_u[11:0]});
                mul_b = 33'(LN2_Q16);
            end
            ST_TT_MUL: begin
                mul_a = $signed({21'd0, r_t});
                mul_b = $signed({21'd0, r_t});
            end
            ST_M_MUL: begin
                mul_a = $signed({16'd0, pow2_frac(r_u[15:12])});
                mul_b = $signed({2'd0, r_p});
            end
            ST_H_MUL: begin
                mul_a = $signed({18'd0, r_raw_h});
                mul_b = $signed({1'b0, r_m});
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_base  <= '0;
            r_ref   <= '0;
            r_slope <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_w     <= 17'd6554;
            r_lim   <= 15'd26;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:   r_en    <= i_cfg_data[0];
                CFG_BASE:     r_base  <= i_cfg_data[15:0];
                CFG_REF:      r_ref   <= i_cfg_data[15:0];
                CFG_SLOPE:    r_slope <= i_cfg_data[15:0];
                CFG_FLOOR:    r_lo    <= i_cfg_data[15:0];
                CFG_CEILING:  r_hi    <= i_cfg_data[15:0];
                CFG_WEIGHT:   r_w     <= i_cfg_data;
                CFG_FAST_LIM: r_lim   <= i_cfg_data[14:0];
                default:      r_en    <= r_en;
            endcase
        end
    end

    // Sequencer state and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
            r_s       <= 16'(CHIP_TEMP_FALLBACK);
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_valid) begin
                if (!r_en) begin
                    r_started <= 1'b0;
                end else if (!r_started) begin
                    r_started <= 1'b1;
                    r_s <= i_chip_sample_valid ? i_chip_temp_sample
                                               : 16'(CHIP_TEMP_FALLBACK);
                end
            end else if (r_state == ST_FLT_ADD) begin
                r_s <= r_s + 16'(flt_sum >>> 16);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_raw_t <= i_raw_temp;
                r_raw_h <= i_raw_humid;
                r_x     <= i_chip_sample_valid ? i_chip_temp_sample
                                               : 16'(CHIP_TEMP_FALLBACK);
                r_tc    <= i_raw_temp;
                r_hum   <= i_raw_humid;
                r_off   <= '0;
                r_path  <= PATH_OFF;
                r_gsel  <= 1'b0;
            end
            ST_FLT_MUL, ST_OFS_MUL, ST_Y_MUL, ST_T_MUL, ST_TT_MUL,
            ST_M_MUL, ST_H_MUL: begin
                r_prod <= mul_p[48:0];
            end
            ST_OFS_ADD: begin
                if (ofs_raw < 36'(lo_eff)) begin
                    r_off <= lo_eff;
                end else if (ofs_raw > 36'(r_hi)) begin
                    r_off <= r_hi;
                end else begin
                    r_off <= 16'(ofs_raw);
                end
            end
            ST_TEMP: begin
                r_tc <= tc_sat;
                if (is_fast) begin
                    r_hum  <= raw_h_clamp;
                    r_path <= PATH_FAST;
                end else if (is_guard) begin
                    r_hum  <= r_raw_h;
                    r_path <= PATH_GUARD;
                end else begin
                    r_path <= PATH_MAGNUS;
                end
            end
            ST_GAM_MUL: begin
                r_prod <= mul_p[48:0];
                r_neg  <= g_t[15];
                r_div  <= DW'(B_S + 20'(g_t));
            end
            ST_DIV_LOAD: begin
                r_rem <= DW'(dividend[NUM_W-1:QW]);
                r_quo <= dividend[QW-1:0];
                r_cnt <= CW'(QW);
            end
            ST_DIV: begin
                r_rem <= q_bit ? DW'(rem2 - {1'b0, r_div}) : DW'(rem2);
                r_quo <= {r_quo[QW-2:0], q_bit};
                r_cnt <= r_cnt - CW'(1);
            end
            ST_DIV_END: begin
                if (r_gsel) begin
                    r_g_cmp <= g_val;
                end else begin
                    r_g_raw <= g_val;
                end
                r_gsel <= 1'b1;
            end
            ST_D_CLAMP: begin
                if (d_full < D_LO) begin
                    r_d <= 21'(D_LO);
                end else if (d_full > D_HI) begin
                    r_d <= 21'(D_HI);
                end else begin
                    r_d <= 21'(d_full);
                end
            end
            ST_Y: begin
                r_n <= 6'(r_prod >>> 32);
                r_u <= r_prod[31:16];
            end
            ST_T:    r_t <= r_prod[27:16];
            ST_P:    r_p <= 31'(1 << 30) + {5'd0, r_t, 14'd0} + 31'(r_prod[23:3]);
            ST_M:    r_m <= r_prod[47:16];
            ST_H:    r_hum <= h_clamp;
            default: r_cnt <= r_cnt;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_temp   <= r_tc;
            r_o_hum    <= r_hum;
            r_o_toff   <= r_off;
            r_o_hoff   <= 16'(r_hum) - 16'(r_raw_h);
            r_o_smooth <= (r_path == PATH_OFF) ? 16'sd0 : r_s;
            r_o_path   <= r_path;
        end
    end

    assign o_valid              = r_ov;
    assign o_temp_out           = r_o_temp;
    assign o_humid_out          = r_o_hum;
    assign o_temp_offset        = r_o_toff;
    assign o_humid_offset       = r_o_hoff;
    assign o_chip_temp_smoothed = r_o_smooth;
    assign o_path               = r_o_path;

    // Checks on the sequencer and results.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt != '0))
        else $error("divider ran past its last quotient bit");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("input taken while sequencer busy");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_temp_out) && $stable(o_path)))
        else $error("pending result lost");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_path == PATH_OFF) |->
        (o_temp_offset == 16'sd0 && o_chip_temp_smoothed == 16'sd0 &&
         o_humid_offset == 16'sd0))
        else $error("disabled result carries nonzero offsets");

    a_humid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_path == PATH_FAST || o_path == PATH_MAGNUS)) |->
        (o_humid_out <= 15'(HUMID_HIGH) && o_humid_out >= 15'(HUMID_LOW)))
        else $error("corrected humidity out of range");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the self-heating temperature and humidity compensation block beat by
// beat against an in-bench predictor of the filter, offset and Magnus math,
// over directed corner items and randomized configuration phases.
// ----------------------------------------------------------------------------
module testbench
    import shthc_pkg::*;
();

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 700;

    typedef struct {
        logic signed [15:0] temp;
        logic [14:0]        humid;
        logic signed [15:0] chip;
        logic               chip_ok;
    } t_sample;

    typedef struct {
        logic signed [15:0] temp_out;
        logic [14:0]        humid_out;
        logic signed [15:0] temp_offset;
        logic signed [15:0] humid_offset;
        logic signed [15:0] chip_avg;
        logic [1:0]         path;
    } t_comp;

    // Bench-side register copies and filter state.
    logic [16:0] reg_copy [0:7];
    longint      avg_chip;
    bit          avg_seeded;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [16:0] cfg_data;
    logic        in_vld;
    logic        dut_ready;
    t_sample     drv;
    logic        out_vld;
    logic        rx_ready;
    t_comp       mon;

    t_sample pending_samples [$];
    t_comp   expected_comps [$];

    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  path_seen [4];
    int  cycles = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  in_taken = 0;
    bit  out_taken = 0;
    bit  no_gaps = 0;
    bit  hold_req = 0;
    bit  big_hold = 0;
    int  hold_cnt = 0;

    self_heating_temp_humidity_comp i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_valid             (in_vld),
        .o_ready             (dut_ready),
        .i_raw_temp          (drv.temp),
        .i_raw_humid         (drv.humid),
        .i_chip_temp_sample  (drv.chip),
        .i_chip_sample_valid (drv.chip_ok),
        .o_valid             (out_vld),
        .i_ready             (rx_ready),
        .o_temp_out          (mon.temp_out),
        .o_humid_out         (mon.humid_out),
        .o_temp_offset       (mon.temp_offset),
        .o_humid_offset      (mon.humid_offset),
        .o_chip_temp_smoothed(mon.chip_avg),
        .o_path              (mon.path)
    );

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // 2^(i/16) in Q16.
    function automatic longint frac_pow2(input int idx);
        longint tbl [16] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                             92682, 96785, 101070, 105545, 110218, 115097, 120193, 125515};
        return tbl[idx];
    endfunction

    // Magnus gamma in Q16, truncated toward zero.
    function automatic longint gamma_q16(input longint t);
        longint num;
        longint den;
        num = longint'(MAGNUS_A_Q) * t * 65536;
        den = (longint'(MAGNUS_B_Q) + t) * (longint'(1) << FRAC_BITS);
        return num / den;
    endfunction

    // Scales humidity by exp(d) through a base-2 table and polynomial.
    function automatic longint exp_scale(input longint rh, input longint d_in);
        longint d, y, n, u, t, p, m;
        longint unsigned prod;
        int s;
        d = d_in;
        if (d < -12 * 65536) d = -12 * 65536;
        if (d > 11 * 65536) d = 11 * 65536;
        y = (d * LOG2E_Q16) >>> 16;
        n = y >>> 16;
        u = y - n * 65536;
        t = ((u & 4095) * LN2_Q16) >> 16;
        p = (longint'(1) << 30) + t * 16384 + ((t * t) >> 3);
        m = (frac_pow2(int'((u >> 12) & 15)) * p) >> 16;
        s = 30 - int'(n);
        prod = longint'(rh) * m;
        prod = (prod + (64'd1 << (s - 1))) >> s;
        if (prod > 65535) prod = 65535;
        return longint'(prod);
    endfunction

    // Predicts one result beat and advances the filter state.
    function automatic t_comp compensate(input t_sample it);
        t_comp r;
        longint rt, rh, x, w, off, lo, hi, tc, diff, hum;
        logic [1:0] pth;
        rt = it.temp;
        rh = it.humid;
        if (reg_copy[CFG_ENABLE][0] == 1'b0) begin
            avg_seeded = 0;
            r.temp_out = it.temp;
            r.humid_out = it.humid;
            r.temp_offset = '0;
            r.humid_offset = '0;
            r.chip_avg = '0;
            r.path = PATH_OFF;
            return r;
        end
        x = it.chip_ok ? longint'(it.chip) : longint'(CHIP_TEMP_FALLBACK);
        if (!avg_seeded) begin
            avg_chip = x;
            avg_seeded = 1;
        end else begin
            w = reg_copy[CFG_WEIGHT];
            if (w > WEIGHT_MAX) w = WEIGHT_MAX;
            avg_chip = avg_chip + ((w * (x - avg_chip) + 32768) >>> 16);
        end
        off = longint'($signed(reg_copy[CFG_BASE][15:0])) +
              (((avg_chip - longint'($signed(reg_copy[CFG_REF][15:0]))) *
                longint'($signed(reg_copy[CFG_SLOPE][15:0])) + 8192) >>> 14);
        lo = $signed(reg_copy[CFG_FLOOR][15:0]);
        hi = $signed(reg_copy[CFG_CEILING][15:0]);
        if (lo > hi) lo = hi;
        if (off < lo) off = lo;
        if (off > hi) off = hi;
        tc = rt - off;
        if (tc < -32768) tc = -32768;
        if (tc > 32767) tc = 32767;
        diff = rt - tc;
        if (diff < 0) diff = -diff;
        if (diff < longint'(reg_copy[CFG_FAST_LIM][14:0])) begin
            hum = rh;
            if (hum < HUMID_LOW) hum = HUMID_LOW;
            if (hum > HUMID_HIGH) hum = HUMID_HIGH;
            pth = PATH_FAST;
        end else if (MAGNUS_B_Q + rt <= (1 << FRAC_BITS) ||
                     MAGNUS_B_Q + tc <= (1 << FRAC_BITS)) begin
            hum = rh;
            pth = PATH_GUARD;
        end else begin
            hum = exp_scale(rh, gamma_q16(rt) - gamma_q16(tc));
            if (hum < HUMID_LOW) hum = HUMID_LOW;
            if (hum > HUMID_HIGH) hum = HUMID_HIGH;
            pth = PATH_MAGNUS;
        end
        r.temp_out = tc[15:0];
        r.humid_out = hum[14:0];
        r.temp_offset = off[15:0];
        r.humid_offset = (hum - rh) & 16'hFFFF;
        r.chip_avg = avg_chip[15:0];
        r.path = pth;
        return r;
    endfunction

    function automatic int draw_gap();
        if (no_gaps || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    // Input acceptance: predict the result of every accepted beat.
    always @(posedge clk) begin
        in_taken <= in_vld && dut_ready;
        if (in_vld && dut_ready) begin
            expected_comps.push_back(compensate(drv));
            beats_in++;
        end
    end

    // Driver: feeds pending samples with random gaps.
    always @(negedge clk) begin
        bit busy;
        bit nv;
        if (rst_n) begin
            busy = in_vld && !in_taken;
            nv = busy;
            if (!busy) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    nv = 0;
                end else if (pending_samples.size() > 0) begin
                    drv <= pending_samples.pop_front();
                    nv = 1;
                    tx_wait = draw_gap();
                end else begin
                    nv = 0;
                end
            end
            in_vld <= nv;
        end
    end

    // Long receiver hold-off, counted here so the block fills and stalls.
    always @(posedge clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            if (hold_cnt == 1) big_hold <= 0;
        end else if (hold_req && !big_hold) begin
            hold_req <= 0;
            big_hold <= 1;
            hold_cnt <= HOLD_CYCLES;
        end
    end

    // Receiver ready with random stalls.
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_taken) rx_wait = draw_gap();
            if (big_hold) begin
                rx_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    // Monitor: compares each result beat with the oldest prediction.
    always @(posedge clk) begin
        t_comp e;
        out_taken <= out_vld && rx_ready;
        if (out_vld && rx_ready) begin
            beats_out++;
            if (expected_comps.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end else begin
                e = expected_comps.pop_front();
                path_seen[mon.path]++;
                if (e.temp_out !== mon.temp_out) begin
                    $display("%0t: temp_out expected %0d actual %0d", $time,
                             e.temp_out, mon.temp_out);
                    errors++;
                end
                if (e.humid_out !== mon.humid_out) begin
                    $display("%0t: humid_out expected %0d actual %0d", $time,
                             e.humid_out, mon.humid_out);
                    errors++;
                end
                if (e.temp_offset !== mon.temp_offset) begin
                    $display("%0t: temp_offset expected %0d actual %0d", $time,
                             e.temp_offset, mon.temp_offset);
                    errors++;
                end
                if (e.humid_offset !== mon.humid_offset) begin
                    $display("%0t: humid_offset expected %0d actual %0d", $time,
                             e.humid_offset, mon.humid_offset);
                    errors++;
                end
                if (e.chip_avg !== mon.chip_avg) begin
                    $display("%0t: chip_temp_smoothed expected %0d actual %0d", $time,
                             e.chip_avg, mon.chip_avg);
                    errors++;
                end
                if (e.path !== mon.path) begin
                    $display("%0t: path expected %0d actual %0d", $time, e.path, mon.path);
                    errors++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    // Register write, mirrored into the predictor's copy.
    task automatic write_reg(input t_cfg_idx idx, input logic [16:0] val);
        logic [16:0] mask;
        mask = (idx == CFG_ENABLE) ? 17'h1 : (idx == CFG_WEIGHT) ? 17'h1FFFF :
               (idx == CFG_FAST_LIM) ? 17'h7FFF : 17'hFFFF;
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        reg_copy[idx] = val & mask;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued beat has been sent and every result checked.
    // Sampled at the rising edge, after the driver's updates have settled.
    task automatic wait_idle();
        do begin
            @(posedge clk);
        end while (pending_samples.size() != 0 || in_vld || expected_comps.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic add_sample(input logic signed [15:0] t, input logic [14:0] h,
                              input logic signed [15:0] c, input logic ok);
        t_sample s;
        s.temp = t;
        s.humid = h;
        s.chip = c;
        s.chip_ok = ok;
        pending_samples.push_back(s);
    endtask

    // Random sample: mostly plausible readings, sometimes any bit pattern.
    task automatic add_random_sample();
        logic signed [15:0] t;
        logic [14:0] h;
        logic signed [15:0] c;
        if ($urandom_range(0, 4) == 0) begin
            t = $urandom();
            h = $urandom();
            c = $urandom();
        end else begin
            t = $urandom_range(0, 16000) - 5000;
            h = $urandom_range(HUMID_LOW, HUMID_HIGH);
            c = $urandom_range(0, 20000) - 2000;
        end
        add_sample(t, h, c, $urandom_range(0, 9) != 0);
    endtask

    // Writes every register for one configuration phase.
    task automatic setup_phase(input int ph);
        logic [16:0] v [0:7];
        v[CFG_ENABLE]   = 17'd1;
        v[CFG_BASE]     = $urandom_range(0, 1500) - 500;
        v[CFG_REF]      = $urandom_range(0, 12800);
        v[CFG_SLOPE]    = $urandom_range(0, 12000) - 4000;
        v[CFG_FLOOR]    = $urandom_range(0, 1000) - 1500;
        v[CFG_CEILING]  = $urandom_range(500, 3000);
        v[CFG_WEIGHT]   = $urandom_range(0, 65536);
        v[CFG_FAST_LIM] = $urandom_range(0, 200);
        case (ph % 8)
            0: begin
                v[CFG_BASE] = 17'h08000;
                v[CFG_REF] = 17'h08000;
                v[CFG_SLOPE] = 17'h08000;
                v[CFG_FLOOR] = 17'h08000;
                v[CFG_CEILING] = 17'h08000;
                v[CFG_WEIGHT] = 17'd0;
                v[CFG_FAST_LIM] = 17'd0;
            end
            1: begin
                v[CFG_BASE] = 17'h07FFF;
                v[CFG_REF] = 17'h07FFF;
                v[CFG_SLOPE] = 17'h07FFF;
                v[CFG_FLOOR] = 17'h07FFF;
                v[CFG_CEILING] = 17'h07FFF;
                v[CFG_WEIGHT] = 17'h1FFFF;
                v[CFG_FAST_LIM] = 17'h7FFF;
            end
            // Floor above ceiling.
            2: begin
                v[CFG_FLOOR] = 17'd2000;
                v[CFG_CEILING] = 17'd300;
                v[CFG_WEIGHT] = 17'd65536;
            end
            3: v[CFG_FLOOR] = 17'h08000;
            // Disabled phase: pass-through and filter restart.
            5: v[CFG_ENABLE] = 17'd0;
            6: begin
                v[CFG_FLOOR] = 17'h08000;
                v[CFG_CEILING] = 17'h07FFF;
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++) write_reg(t_cfg_idx'(i), v[i]);
    endtask

    // Stimulus sequencing.
    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_vld = 1'b0;
        rx_ready = 1'b0;
        drv = '{temp: '0, humid: '0, chip: '0, chip_ok: 1'b0};
        reg_copy[CFG_ENABLE] = 0;
        reg_copy[CFG_BASE] = 0;
        reg_copy[CFG_REF] = 0;
        reg_copy[CFG_SLOPE] = 0;
        reg_copy[CFG_FLOOR] = 0;
        reg_copy[CFG_CEILING] = 0;
        reg_copy[CFG_WEIGHT] = 6554;
        reg_copy[CFG_FAST_LIM] = 26;
        avg_chip = CHIP_TEMP_FALLBACK;
        avg_seeded = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: pass-through while disabled after reset.
        add_sample(16'sh8000, 15'h7FFF, 16'sh7FFF, 1'b1);
        add_sample(16'sh7FFF, 15'd0, 16'sh8000, 1'b0);
        wait_idle();

        // Directed: enabled with moderate self-heating, corner readings.
        write_reg(CFG_BASE, 17'd512);
        write_reg(CFG_REF, 17'd7680);
        write_reg(CFG_SLOPE, 17'd4096);
        write_reg(CFG_FLOOR, 17'h0FF00);
        write_reg(CFG_CEILING, 17'd1280);
        write_reg(CFG_ENABLE, 17'd1);
        add_sample(16'd6400, 15'd12800, 16'd9000, 1'b1);  // seeds the filter
        add_sample(16'd6400, 15'd12800, 16'd9000, 1'b0);  // fallback chip temp
        add_sample(16'sh8000, 15'd0, 16'sh8000, 1'b1);
        add_sample(16'sh7FFF, 15'd25600, 16'sh7FFF, 1'b1);
        add_sample(16'd0, 15'h7FFF, 16'd0, 1'b1);         // humidity above range
        add_sample(16'd2560, 15'd25600, 16'd30000, 1'b1);  // chip sample far above the reference
        add_sample(16'sh0F000, 15'd5000, 16'sh8000, 1'b1); // chip sample at the negative extreme
        add_sample(16'd5120, 15'd25000, 16'd7680, 1'b1);   // chip sample at the reference
        add_sample(16'd1, 15'd1, 16'd7690, 1'b1);
        add_sample(16'shFFFF, 15'd100, 16'd12800, 1'b0);
        wait_idle();
        // Tiny offset: fast path.
        write_reg(CFG_SLOPE, 17'd0);
        write_reg(CFG_BASE, 17'd10);
        write_reg(CFG_FAST_LIM, 17'd26);
        add_sample(16'd6400, 15'd25600, 16'd100, 1'b1);
        add_sample(16'd6400, 15'h7FFF, 16'd100, 1'b1);
        wait_idle();

        // Random phases.
        for (int ph = 0; ph < 16; ph++) begin
            setup_phase(ph);
            no_gaps = (ph % 4 == 3);
            if (ph == 4) hold_req = 1;
            for (int k = 0; k < 102; k++) add_random_sample();
            wait_idle();
        end

        repeat (20) @(negedge clk);
        $display("run: %0d beats in, %0d out; paths off %0d fast %0d magnus %0d guard %0d",
                 beats_in, beats_out, path_seen[0], path_seen[1], path_seen[2],
                 path_seen[3]);
        $display("configuration phases covered register extremes and a long output stall");
        if (errors == 0 && expected_comps.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

### sim.f
design/shthc_pkg.sv
design/self_heating_temp_humidity_comp.sv
tb/sv/testbench.sv
